>>> hdl/smasm_pkg.sv
// shared types, constants and helpers of the symmetric 3x3 matrix add/subtract/multiply core
package smasm_pkg;

   localparam int DATA_W            = 32;
   localparam int IDX_W             = 2;
   localparam int CSR_ADDR_W        = 3;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH       = 4;
   localparam int QUEUE_CNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef logic [1:0] mode_type;

   localparam mode_type MODE_ADD = 2'd0;
   localparam mode_type MODE_SUB = 2'd1;
   localparam mode_type MODE_MUL = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] REG_MODE     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_ENTRY_00 = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_ENTRY_01 = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_ENTRY_02 = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_ENTRY_11 = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_ENTRY_12 = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_ENTRY_22 = 3'd6;

   localparam logic [IDX_W-1:0] LAST_IDX = 2'd2;

   typedef struct packed {
      logic signed [DATA_W-1:0] e00;
      logic signed [DATA_W-1:0] e01;
      logic signed [DATA_W-1:0] e02;
      logic signed [DATA_W-1:0] e11;
      logic signed [DATA_W-1:0] e12;
      logic signed [DATA_W-1:0] e22;
   } sym_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] element;
      logic [IDX_W-1:0]         row;
      logic [IDX_W-1:0]         col;
      mode_type                 mode;
      logic                     last;
   } item_type;

   typedef struct packed {
      logic                        burst;
      logic [IDX_W-1:0]            row;
      logic [IDX_W-1:0]            col;
      logic                        last;
      logic [2:0][DATA_W-1:0]      value;
   } result_type;

   function automatic logic signed [DATA_W-1:0] stored_at(sym_type s, logic [IDX_W-1:0] r,
                                                          logic [IDX_W-1:0] c);
      logic [IDX_W-1:0]         lo;
      logic [IDX_W-1:0]         hi;
      logic signed [DATA_W-1:0] v;
      lo = (r < c) ? r : c;
      hi = (r < c) ? c : r;
      if (lo == 2'd0) begin
         if (hi == 2'd0) begin
            v = s.e00;
         end else if (hi == 2'd1) begin
            v = s.e01;
         end else begin
            v = s.e02;
         end
      end else if (lo == 2'd1) begin
         v = (hi == 2'd1) ? s.e11 : s.e12;
      end else begin
         v = s.e22;
      end
      return v;
   endfunction

endpackage

>>> hdl/smasm_datapath.sv
// item and product pipeline with column accumulators and saturation
module smasm_datapath #(
   parameter int FRAC_BITS = smasm_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  smasm_pkg::item_type   in_item,
   input  smasm_pkg::sym_type    sym,
   output logic [1:0]            occupancy,
   output logic                  push_valid,
   output smasm_pkg::result_type push_data
);

   localparam int DW     = smasm_pkg::DATA_W;
   localparam int IW     = smasm_pkg::IDX_W;
   localparam int PROD_W = 2 * DW;
   localparam int ACC_W  = PROD_W - FRAC_BITS + 2;

   localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

   logic                s1_valid_ff;
   smasm_pkg::item_type s1_item_ff;
   logic                s2_valid_ff;
   smasm_pkg::item_type s2_item_ff;

   logic signed [PROD_W-1:0] prod_ff [3];
   logic signed [PROD_W-1:0] prod_in [3];
   logic signed [DW-1:0]     sum_ff;
   logic signed [DW-1:0]     sum_in;

   logic signed [ACC_W-1:0] acc_ff [3][3];
   logic signed [ACC_W-1:0] acc_in [3];
   logic signed [DW-1:0]    acc_sat [3];

   logic signed [DW-1:0] elem;
   logic signed [DW-1:0] st_rc;
   logic signed [DW:0]   as_sum;

   // stage one: products and add/subtract
   always_comb begin
      logic signed [DW-1:0] st;
      elem  = s1_item_ff.element;
      st_rc = smasm_pkg::stored_at(sym, s1_item_ff.row, s1_item_ff.col);
      for (int r = 0; r < 3; r++) begin
         st         = smasm_pkg::stored_at(sym, IW'(r), s1_item_ff.row);
         prod_in[r] = st * elem;
      end
      if (s1_item_ff.mode == smasm_pkg::MODE_SUB) begin
         as_sum = (DW+1)'(elem) - (DW+1)'(st_rc);
      end else begin
         as_sum = (DW+1)'(elem) + (DW+1)'(st_rc);
      end
      if (as_sum[DW] != as_sum[DW-1]) begin
         sum_in = as_sum[DW] ? SAT_MIN : SAT_MAX;
      end else begin
         sum_in = as_sum[DW-1:0];
      end
   end

   // stage two: accumulate the column and saturate
   always_comb begin
      logic signed [ACC_W-1:0] sh;
      logic signed [ACC_W-1:0] base;
      logic [ACC_W-DW:0]       top;
      for (int r = 0; r < 3; r++) begin
         sh   = ACC_W'(prod_ff[r] >>> FRAC_BITS);
         base = (s2_item_ff.row == 2'd0) ? '0 : acc_ff[r][s2_item_ff.col];
         acc_in[r] = base + sh;
         top = acc_in[r][ACC_W-1:DW-1];
         if (!((&top) || !(|top))) begin
            acc_sat[r] = acc_in[r][ACC_W-1] ? SAT_MIN : SAT_MAX;
         end else begin
            acc_sat[r] = acc_in[r][DW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         s1_item_ff <= in_item;
      end
      if (s1_valid_ff) begin
         s2_item_ff <= s1_item_ff;
         sum_ff     <= sum_in;
         for (int r = 0; r < 3; r++) begin
            prod_ff[r] <= prod_in[r];
         end
      end
      if (s2_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            acc_ff[r][s2_item_ff.col] <= acc_in[r];
         end
      end
   end

   always_comb begin
      occupancy  = {1'b0, s1_valid_ff} + {1'b0, s2_valid_ff};
      push_valid = s2_valid_ff && ((s2_item_ff.mode != smasm_pkg::MODE_MUL) ||
                                   (s2_item_ff.row == smasm_pkg::LAST_IDX));
      push_data.burst    = (s2_item_ff.mode == smasm_pkg::MODE_MUL);
      push_data.row      = s2_item_ff.row;
      push_data.col      = s2_item_ff.col;
      push_data.last     = s2_item_ff.last;
      push_data.value[0] = push_data.burst ? acc_sat[0] : sum_ff;
      push_data.value[1] = acc_sat[1];
      push_data.value[2] = acc_sat[2];
   end

endmodule

>>> hdl/smasm_result_queue.sv
// result queue: one entry per single result or three-result column burst, unpacked at the output
module smasm_result_queue (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   push_valid,
   input  smasm_pkg::result_type                  push_data,
   output logic [smasm_pkg::QUEUE_CNT_W-1:0]      count,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [smasm_pkg::IDX_W-1:0]            rsp_out_row,
   output logic [smasm_pkg::IDX_W-1:0]            rsp_out_col,
   output logic signed [smasm_pkg::DATA_W-1:0]    rsp_out_value,
   output logic                                   rsp_matrix_done
);

   localparam int DEPTH = smasm_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = smasm_pkg::QUEUE_CNT_W;

   smasm_pkg::result_type mem_ff [DEPTH];
   smasm_pkg::result_type head;

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       sub_ff, sub_in;
   logic             beat;
   logic             pop;
   logic             sub_last;

   always_comb begin
      head      = mem_ff[rd_ptr_ff];
      rsp_valid = (count_ff != '0);
      beat      = rsp_valid && rsp_ready;
      sub_last  = (sub_ff == smasm_pkg::LAST_IDX);
      pop       = beat && (!head.burst || sub_last);

      if (pop) begin
         sub_in = 2'd0;
      end else if (beat) begin
         sub_in = sub_ff + 2'd1;
      end else begin
         sub_in = sub_ff;
      end

      wr_ptr_in = push_valid ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push_valid) - CNT_W'(pop);

      count           = count_ff;
      rsp_out_row     = head.burst ? sub_ff : head.row;
      rsp_out_col     = head.col;
      rsp_out_value   = head.value[sub_ff];
      rsp_matrix_done = head.last && (!head.burst || sub_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sub_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sub_ff    <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/symmetric_matrix_add_sub_multiply_core.sv
// top level of the symmetric 3x3 matrix add/subtract/multiply core
//
// usage: write mode and the six upper-triangle entries of S through the csr port
// while idle, then stream a 3x3 matrix M one element per item on req_, row-major.
// add and subtract modes give one result item per element (M+S or M-S).
// multiply mode gives nothing for rows 0 and 1 and three result items, rows 0..2 of
// that column of S*M, when the row 2 element of a column arrives.
// rsp_matrix_done marks the result at row 2, column 2.
// an accepted item passes the input register, then the product register, then the
// result queue before its first result shows. throughput: one item per cycle
// while req_ready holds; a column burst drains one result per cycle while
// rsp_ready holds. the result queue holds four entries; req_ready drops only when
// the queue plus the up to two items in the pipeline could fill it, so a stalled
// receiver backs up into req_ready without losing anything.
// reset: mode and entries clear to zero, the element position returns to row 0,
// column 0, and the queue empties.
module symmetric_matrix_add_sub_multiply_core #(
   parameter int FRAC_BITS = smasm_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [smasm_pkg::DATA_W-1:0]    req_element,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [smasm_pkg::IDX_W-1:0]            rsp_out_row,
   output logic [smasm_pkg::IDX_W-1:0]            rsp_out_col,
   output logic signed [smasm_pkg::DATA_W-1:0]    rsp_out_value,
   output logic                                   rsp_matrix_done,
   input  logic                                   csr_we,
   input  logic [smasm_pkg::CSR_ADDR_W-1:0]       csr_index,
   input  logic [smasm_pkg::DATA_W-1:0]           csr_wdata
);

   localparam int CNT_W = smasm_pkg::QUEUE_CNT_W;

   smasm_pkg::mode_type   mode_ff;
   smasm_pkg::sym_type    sym_ff;
   logic [smasm_pkg::IDX_W-1:0] row_ff, row_in;
   logic [smasm_pkg::IDX_W-1:0] col_ff, col_in;

   logic                  accept;
   smasm_pkg::item_type   item;
   logic [1:0]            occupancy;
   logic [CNT_W-1:0]      count;
   logic [CNT_W:0]        used;
   logic                  push_valid;
   smasm_pkg::result_type push_data;

   always_comb begin
      used      = (CNT_W+1)'(count) + (CNT_W+1)'(occupancy);
      req_ready = (used < (CNT_W+1)'(smasm_pkg::QUEUE_DEPTH));
      accept    = req_valid && req_ready;

      item.element = req_element;
      item.row     = row_ff;
      item.col     = col_ff;
      item.mode    = mode_ff;
      item.last    = (row_ff == smasm_pkg::LAST_IDX) && (col_ff == smasm_pkg::LAST_IDX);

      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (col_ff == smasm_pkg::LAST_IDX) begin
            col_in = 2'd0;
            row_in = (row_ff == smasm_pkg::LAST_IDX) ? 2'd0 : row_ff + 2'd1;
         end else begin
            col_in = col_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= 2'd0;
         col_ff <= 2'd0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= smasm_pkg::MODE_ADD;
         sym_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            smasm_pkg::REG_MODE:     mode_ff    <= csr_wdata[1:0];
            smasm_pkg::REG_ENTRY_00: sym_ff.e00 <= csr_wdata;
            smasm_pkg::REG_ENTRY_01: sym_ff.e01 <= csr_wdata;
            smasm_pkg::REG_ENTRY_02: sym_ff.e02 <= csr_wdata;
            smasm_pkg::REG_ENTRY_11: sym_ff.e11 <= csr_wdata;
            smasm_pkg::REG_ENTRY_12: sym_ff.e12 <= csr_wdata;
            smasm_pkg::REG_ENTRY_22: sym_ff.e22 <= csr_wdata;
            default: ;
         endcase
      end
   end

   smasm_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_item    (item),
      .sym        (sym_ff),
      .occupancy  (occupancy),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   smasm_result_queue u_result_queue (
      .clock           (clock),
      .reset           (reset),
      .push_valid      (push_valid),
      .push_data       (push_data),
      .count           (count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_value   (rsp_out_value),
      .rsp_matrix_done (rsp_matrix_done)
   );

endmodule

>>> hdl/smasm_checker.sv
// port-level checker of the symmetric 3x3 matrix core and its bind
module smasm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [smasm_pkg::IDX_W-1:0]         rsp_out_row,
   input logic [smasm_pkg::IDX_W-1:0]         rsp_out_col,
   input logic signed [smasm_pkg::DATA_W-1:0] rsp_out_value,
   input logic                                rsp_matrix_done
);

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_reset_ready : assert property (@(posedge clock) reset |=> req_ready)
      else $error("not ready for an item right after reset");

   a_done_corner : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_matrix_done |->
         rsp_out_row == smasm_pkg::LAST_IDX && rsp_out_col == smasm_pkg::LAST_IDX)
      else $error("matrix done flagged away from the last element");

   a_index_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_row != 2'd3 && rsp_out_col != 2'd3)
      else $error("result index out of range");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_out_value) && $stable(rsp_out_row) &&
         $stable(rsp_out_col) && $stable(rsp_matrix_done))
      else $error("stalled result item changed");

endmodule

bind symmetric_matrix_add_sub_multiply_core smasm_checker u_smasm_checker (.*);
